@@ src/stt2_pkg.sv @@
// ----------------------------------------------------------------------------
// Step toward target package
// Shared widths, action codes and sequencer states of the 2-D mover.
// ----------------------------------------------------------------------------
package stt2_pkg;

  localparam int COORD_BITS  = 24;
  localparam int LIMIT_W     = COORD_BITS;
  localparam int GAP_W       = COORD_BITS + 1;
  localparam int PROD_W      = 2 * COORD_BITS;
  localparam int SQ_W        = PROD_W + 1;
  localparam int RAD_W       = 2 * GAP_W;
  localparam int SREM_W      = GAP_W + 1;
  localparam int ALU_W       = SREM_W + 2;
  localparam int CNT_W       = $clog2(GAP_W);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(205);

  typedef enum logic {
    ACT_MOVE  = 1'b0,
    ACT_PLACE = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AX,
    ST_MUL_AY,
    ST_MUL_LIM,
    ST_MUL_STEP,
    ST_CMP,
    ST_SQRT,
    ST_MUL_DX,
    ST_LOAD_DX,
    ST_DIV_X,
    ST_MUL_DY,
    ST_LOAD_DY,
    ST_DIV_Y,
    ST_DONE
  } state_t;

endpackage

@@ src/stt2_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Step toward target command channel
// Valid/ready channel carrying one destination, step length and action.
// ----------------------------------------------------------------------------
interface stt2_cmd_if import stt2_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] dest_x;
  logic [COORD_BITS-1:0] dest_y;
  logic [COORD_BITS-1:0] step_length;

  modport source (output valid, output action, output dest_x, output dest_y,
                  output step_length, input ready);
  modport sink (input valid, input action, input dest_x, input dest_y,
                input step_length, output ready);
endinterface

@@ src/stt2_res_if.sv @@
// ----------------------------------------------------------------------------
// Step toward target result channel
// Valid/ready channel carrying the new position, gap and status flags.
// ----------------------------------------------------------------------------
interface stt2_res_if import stt2_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] new_x;
  logic [COORD_BITS-1:0] new_y;
  logic [GAP_W-1:0]      gap;
  logic                  arrived;
  logic                  near;

  modport source (output valid, output new_x, output new_y, output gap,
                  output arrived, output near, input ready);
  modport sink (input valid, input new_x, input new_y, input gap,
                input arrived, input near, output ready);
endinterface

@@ src/step_toward_target_2d.sv @@
// ----------------------------------------------------------------------------
// Step toward target 2-D
// Moves a Q12.12 position toward a destination by a clamped step length.
// ----------------------------------------------------------------------------
// Each command transaction produces exactly one result transaction. A command
// is taken only in the idle state, after the previous result has been loaded
// into the result register, so commands are never overlapped.
// The work per command is one 25-step square root and two 24-step divisions,
// all run on a single shared subtractor, plus six products through one
// 24x24 multiplier. The command side is ready again while a result still
// waits to be taken; the result register holds it until accepted.
module step_toward_target_2d import stt2_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  stt2_cmd_if.sink           cmd,
  stt2_res_if.source         res
);

  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(GAP_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(COORD_BITS - 1);

  state_t state, state_next;

  logic [LIMIT_W-1:0]    closeness;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic                  act;
  logic [COORD_BITS-1:0] dest_x;
  logic [COORD_BITS-1:0] dest_y;
  logic [COORD_BITS-1:0] step;
  logic                  dir_x;
  logic                  dir_y;
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic [PROD_W-1:0]     prod;
  logic [SQ_W-1:0]       sq;
  logic                  near_flag;
  logic                  snap;
  logic [RAD_W-1:0]      sh;
  logic [SREM_W-1:0]     rem;
  logic [GAP_W-1:0]      root;
  logic [COORD_BITS-1:0] quo;
  logic [COORD_BITS-1:0] qx;
  logic [CNT_W-1:0]      cnt;

  logic [COORD_BITS-1:0] mul_a;
  logic [COORD_BITS-1:0] mul_b;
  logic [PROD_W-1:0]     product;
  logic [ALU_W-1:0]      alu_a;
  logic [ALU_W-1:0]      alu_b;
  logic [ALU_W:0]        diff;
  logic                  borrow;
  logic                  res_load;
  logic                  place_now;
  logic                  g_zero;
  logic [COORD_BITS-1:0] nx;
  logic [COORD_BITS-1:0] ny;

  // The one multiplier, its operands chosen by the sequencer.
  always_comb begin
    unique case (state)
      ST_MUL_AX:   begin mul_a = ax;        mul_b = ax;        end
      ST_MUL_AY:   begin mul_a = ay;        mul_b = ay;        end
      ST_MUL_LIM:  begin mul_a = closeness; mul_b = closeness; end
      ST_MUL_STEP: begin mul_a = step;      mul_b = step;      end
      ST_MUL_DX:   begin mul_a = step;      mul_b = ax;        end
      ST_MUL_DY:   begin mul_a = step;      mul_b = ay;        end
      default:     begin mul_a = '0;        mul_b = '0;        end
    endcase
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  // The shared trial subtractor serves both the square root and the divisions.
  always_comb begin
    if (state == ST_SQRT) begin
      alu_a = {rem, sh[RAD_W-1 -: 2]};
      alu_b = ALU_W'({root, 2'b01});
    end else begin
      alu_a = ALU_W'({rem, sh[RAD_W-1]});
      alu_b = ALU_W'(root);
    end
  end

  assign diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign borrow = diff[ALU_W];

  assign res_load  = (state == ST_DONE) && (!res.valid || res.ready);
  assign place_now = (act == ACT_PLACE) || snap;
  assign g_zero    = (root == '0);

  always_comb begin
    if (place_now) begin
      nx = dest_x;
      ny = dest_y;
    end else if (g_zero) begin
      nx = pos_x;
      ny = pos_y;
    end else begin
      nx = dir_x ? pos_x + qx : pos_x - qx;
      ny = dir_y ? pos_y + quo : pos_y - quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = ST_MUL_AX;
        end
      end
      ST_MUL_AX:   state_next = ST_MUL_AY;
      ST_MUL_AY:   state_next = ST_MUL_LIM;
      ST_MUL_LIM:  state_next = ST_MUL_STEP;
      ST_MUL_STEP: state_next = ST_CMP;
      ST_CMP:      state_next = ST_SQRT;
      ST_SQRT: begin
        if (cnt == '0) begin
          state_next = ST_MUL_DX;
        end
      end
      ST_MUL_DX:  state_next = ST_LOAD_DX;
      ST_LOAD_DX: state_next = ST_DIV_X;
      ST_DIV_X: begin
        if (cnt == '0) begin
          state_next = ST_MUL_DY;
        end
      end
      ST_MUL_DY:  state_next = ST_LOAD_DY;
      ST_LOAD_DY: state_next = ST_DIV_Y;
      ST_DIV_Y: begin
        if (cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res.valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      closeness <= LIMIT_RESET;
      pos_x     <= '0;
      pos_y     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        closeness <= cfg_wr_data;
      end
      if (res_load) begin
        pos_x     <= nx;
        pos_y     <= ny;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          act    <= cmd.action;
          dest_x <= cmd.dest_x;
          dest_y <= cmd.dest_y;
          step   <= cmd.step_length;
          dir_x  <= (cmd.dest_x >= pos_x);
          dir_y  <= (cmd.dest_y >= pos_y);
          ax     <= (cmd.dest_x >= pos_x) ? cmd.dest_x - pos_x : pos_x - cmd.dest_x;
          ay     <= (cmd.dest_y >= pos_y) ? cmd.dest_y - pos_y : pos_y - cmd.dest_y;
        end
      end
      ST_MUL_AX: prod <= product;
      ST_MUL_AY: begin
        prod <= product;
        sq   <= SQ_W'(prod);
      end
      ST_MUL_LIM: begin
        prod <= product;
        sq   <= sq + SQ_W'(prod);
      end
      ST_MUL_STEP: begin
        prod      <= product;
        near_flag <= (sq < SQ_W'(prod));
      end
      ST_CMP: begin
        snap <= (sq < SQ_W'(prod));
        sh   <= RAD_W'(sq);
        rem  <= '0;
        root <= '0;
        cnt  <= SQRT_LAST;
      end
      ST_SQRT: begin
        sh  <= sh << 2;
        cnt <= cnt - 1'b1;
        if (!borrow) begin
          rem  <= diff[SREM_W-1:0];
          root <= {root[GAP_W-2:0], 1'b1};
        end else begin
          rem  <= alu_a[SREM_W-1:0];
          root <= {root[GAP_W-2:0], 1'b0};
        end
      end
      ST_MUL_DX: prod <= product;
      ST_MUL_DY: begin
        prod <= product;
        qx   <= quo;
      end
      ST_LOAD_DX, ST_LOAD_DY: begin
        rem <= SREM_W'(prod[PROD_W-1:COORD_BITS]);
        sh  <= {prod[COORD_BITS-1:0], (RAD_W - COORD_BITS)'(0)};
        cnt <= DIV_LAST;
      end
      ST_DIV_X, ST_DIV_Y: begin
        sh  <= sh << 1;
        cnt <= cnt - 1'b1;
        quo <= {quo[COORD_BITS-2:0], !borrow};
        rem <= borrow ? alu_a[SREM_W-1:0] : diff[SREM_W-1:0];
      end
      ST_DONE: begin
        if (res_load) begin
          res.new_x   <= nx;
          res.new_y   <= ny;
          res.gap     <= root;
          res.arrived <= place_now;
          res.near    <= near_flag;
        end
      end
      default: ;
    endcase
  end

  // The square root is the floor root: root squared fits, root plus one squared does not.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_DX) |->
      ((RAD_W'(root) * RAD_W'(root)) <= RAD_W'(sq)) &&
      (((RAD_W'(root) + 1'b1) * (RAD_W'(root) + 1'b1)) > RAD_W'(sq)))
    else $error("square root result is not the floor root of the distance");

  // A move that does not snap never has a step longer than the gap.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && !place_now |-> (GAP_W'(step) <= root))
    else $error("non-snapping move with step above the gap");

  // Each advance stays within the remaining delta of its coordinate.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && !place_now && !g_zero |-> (qx <= ax) && (quo <= ay))
    else $error("advance overshoots the destination");

  // Accepting a command keeps the command side closed on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready && (state == ST_MUL_AX))
    else $error("command side reopened while a transaction is in progress");

endmodule
